### rtl/mmtt_pkg.sv
// ----------------------------------------------------------------------------
// mmtt_pkg: shared types and codes for the Modbus master transaction tracker
// Beat layouts, event and status codes, function codes and tracker phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mmtt_pkg;

	// item kinds
	localparam logic [1:0] MODE_ISSUE     = 2'd0;
	localparam logic [1:0] MODE_RESPONSE  = 2'd1;
	localparam logic [1:0] MODE_EXCEPTION = 2'd2;
	localparam logic [1:0] MODE_TICK      = 2'd3;

	// result events
	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_SENT    = 3'd1;
	localparam logic [2:0] EV_OK      = 3'd2;
	localparam logic [2:0] EV_FAIL    = 3'd3;
	localparam logic [2:0] EV_REFUSED = 3'd4;

	// result status
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BUSY     = 3'd1;
	localparam logic [2:0] ST_PROTOCOL = 3'd2;
	localparam logic [2:0] ST_TIMEOUT  = 3'd3;
	localparam logic [2:0] ST_MODBUS   = 3'd4;
	localparam logic [2:0] ST_INVALID  = 3'd5;
	localparam logic [2:0] ST_NO_TRANS = 3'd6;

	// Modbus function codes and markers
	localparam logic [7:0]  FN_READ_INPUT   = 8'h04;
	localparam logic [7:0]  FN_WRITE_ONE    = 8'h06;
	localparam logic [7:0]  FN_WRITE_MANY   = 8'h10;
	localparam logic [15:0] REJECT_MARK     = 16'hFFFF;
	localparam logic [7:0]  MAX_WRITE_BYTES = 8'd246;
	localparam logic [7:0]  MIN_WRITE_RESP  = 8'd4;

	localparam logic [31:0] TIMEOUT_RESET = 32'd4000;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_READ  = 3'b010,
		PH_WRITE = 3'b100
	} phase_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  function_select;
		logic [15:0] target_address;
		logic [7:0]  payload_length;
		logic [15:0] payload_value;
		logic [7:0]  expected_length;
		logic [7:0]  response_length;
		logic [15:0] response_address;
		logic [15:0] echo_value;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [2:0]  status;
		logic [7:0]  send_function;
		logic [15:0] send_address;
		logic [6:0]  send_count;
		logic [7:0]  send_bytes;
		logic        busy_res;
		logic        write_pending;
	} out_item_t;

endpackage

`default_nettype wire

### rtl/modbus_master_transaction_tracker.sv
// ----------------------------------------------------------------------------
// modbus_master_transaction_tracker: one-at-a-time Modbus master tracker
// Checks commands, builds the request to send, and closes the transaction
// on a response, an exception or a timeout.
// ----------------------------------------------------------------------------
// Each input beat is a command, a response summary, an exception or a time
// tick, and yields exactly one result beat. An accepted beat is held in an
// input register; it is decided combinationally, against the pending
// transaction, as it moves into the result register, and the block sustains
// one beat per clock whenever the result side takes one beat per clock. The
// input register is refilled in the same cycle that it drains; while a result
// waits on the output the held beat stays put and in_ready drops, so at most
// two beats are held inside until the result side takes one. The timeout
// register is written through cfg_wr_en / cfg_wr_data and resets to 4000
// ticks; write it only while no transaction beat is in flight. The elapsed
// tick count saturates, so the all-ones timeout never expires.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module modbus_master_transaction_tracker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire mmtt_pkg::in_item_t in_data,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      mmtt_pkg::out_item_t out_data,
	input  wire logic               cfg_wr_en,
	input  wire logic [31:0]        cfg_wr_data
);

	// input register stage
	mmtt_pkg::in_item_t  item_s1;
	logic                valid_s1;
	// result register stage
	mmtt_pkg::out_item_t res_s2;
	logic                valid_s2;

	// timeout setting and pending transaction state
	logic [31:0]      timeout_q;
	mmtt_pkg::phase_t phase_q, phase_d;
	logic [7:0]       pend_fn_q, pend_fn_d;
	logic [15:0]      pend_addr_q, pend_addr_d;
	logic [7:0]       pend_elen_q, pend_elen_d;
	logic [15:0]      pend_wval_q, pend_wval_d;
	logic [31:0]      elapsed_q, elapsed_d;

	mmtt_pkg::out_item_t res_d;
	logic                advance;
	logic [31:0]         elapsed_inc;
	logic [7:0]          padded;

	// move the held beat on whenever the result register is free or draining
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	// saturating tick count, and the padded byte count of a multiple write
	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 32'd1;
	assign padded      = item_s1.payload_length + {7'd0, item_s1.payload_length[0]};

	// decide the held beat against the pending transaction
	always_comb begin
		res_d       = '0;
		phase_d     = phase_q;
		pend_fn_d   = pend_fn_q;
		pend_addr_d = pend_addr_q;
		pend_elen_d = pend_elen_q;
		pend_wval_d = pend_wval_q;
		elapsed_d   = elapsed_q;

		res_d.event_res = mmtt_pkg::EV_NONE;
		res_d.status    = mmtt_pkg::ST_OK;

		case (item_s1.mode)
			mmtt_pkg::MODE_ISSUE: begin
				if (phase_q != mmtt_pkg::PH_IDLE) begin
					res_d.event_res = mmtt_pkg::EV_REFUSED;
					res_d.status    = mmtt_pkg::ST_BUSY;
				end else if (item_s1.function_select == mmtt_pkg::FN_READ_INPUT) begin
					res_d.event_res     = mmtt_pkg::EV_SENT;
					res_d.send_function = item_s1.function_select;
					res_d.send_address  = item_s1.target_address;
					res_d.send_count    = item_s1.expected_length[7:1];
					res_d.send_bytes    = 8'd0;
					phase_d     = mmtt_pkg::PH_READ;
					pend_fn_d   = item_s1.function_select;
					pend_addr_d = item_s1.target_address;
					pend_elen_d = item_s1.expected_length;
					pend_wval_d = 16'd0;
					elapsed_d   = 32'd0;
				end else if (item_s1.function_select == mmtt_pkg::FN_WRITE_ONE) begin
					if (item_s1.payload_length == 8'd1 || item_s1.payload_length == 8'd2) begin
						res_d.event_res     = mmtt_pkg::EV_SENT;
						res_d.send_function = item_s1.function_select;
						res_d.send_address  = item_s1.target_address;
						res_d.send_count    = 7'd1;
						res_d.send_bytes    = 8'd2;
						phase_d     = mmtt_pkg::PH_WRITE;
						pend_fn_d   = item_s1.function_select;
						pend_addr_d = item_s1.target_address;
						pend_elen_d = 8'd0;
						// pad a lone byte with a leading zero
						pend_wval_d = (item_s1.payload_length == 8'd1) ?
							{8'd0, item_s1.payload_value[7:0]} : item_s1.payload_value;
						elapsed_d   = 32'd0;
					end else begin
						res_d.event_res = mmtt_pkg::EV_REFUSED;
						res_d.status    = mmtt_pkg::ST_PROTOCOL;
					end
				end else if (item_s1.function_select == mmtt_pkg::FN_WRITE_MANY) begin
					if (item_s1.payload_length <= mmtt_pkg::MAX_WRITE_BYTES) begin
						res_d.event_res     = mmtt_pkg::EV_SENT;
						res_d.send_function = item_s1.function_select;
						res_d.send_address  = item_s1.target_address;
						res_d.send_count    = padded[7:1];
						res_d.send_bytes    = padded;
						phase_d     = mmtt_pkg::PH_WRITE;
						pend_fn_d   = item_s1.function_select;
						pend_addr_d = item_s1.target_address;
						pend_elen_d = 8'd0;
						pend_wval_d = 16'd0;
						elapsed_d   = 32'd0;
					end else begin
						res_d.event_res = mmtt_pkg::EV_REFUSED;
						res_d.status    = mmtt_pkg::ST_PROTOCOL;
					end
				end else begin
					res_d.event_res = mmtt_pkg::EV_REFUSED;
					res_d.status    = mmtt_pkg::ST_PROTOCOL;
				end
			end
			mmtt_pkg::MODE_RESPONSE: begin
				res_d.event_res = mmtt_pkg::EV_FAIL;
				if (phase_q == mmtt_pkg::PH_IDLE) begin
					res_d.status = mmtt_pkg::ST_NO_TRANS;
				end else begin
					if (item_s1.response_length == 8'd0) begin
						res_d.status = mmtt_pkg::ST_PROTOCOL;
					end else if (phase_q == mmtt_pkg::PH_READ) begin
						if (item_s1.response_length != pend_elen_q) begin
							res_d.status = mmtt_pkg::ST_PROTOCOL;
						end else begin
							res_d.event_res = mmtt_pkg::EV_OK;
						end
					end else if (item_s1.response_length < mmtt_pkg::MIN_WRITE_RESP ||
							item_s1.response_address != pend_addr_q) begin
						res_d.status = mmtt_pkg::ST_PROTOCOL;
					end else if (pend_fn_q == mmtt_pkg::FN_WRITE_ONE &&
							item_s1.echo_value == mmtt_pkg::REJECT_MARK) begin
						res_d.status = mmtt_pkg::ST_MODBUS;
					end else if (pend_fn_q == mmtt_pkg::FN_WRITE_ONE &&
							item_s1.echo_value != pend_wval_q) begin
						res_d.status = mmtt_pkg::ST_INVALID;
					end else begin
						res_d.event_res = mmtt_pkg::EV_OK;
					end
					phase_d = mmtt_pkg::PH_IDLE;
				end
			end
			mmtt_pkg::MODE_EXCEPTION: begin
				res_d.event_res = mmtt_pkg::EV_FAIL;
				if (phase_q == mmtt_pkg::PH_IDLE) begin
					res_d.status = mmtt_pkg::ST_NO_TRANS;
				end else begin
					res_d.status = mmtt_pkg::ST_MODBUS;
					phase_d      = mmtt_pkg::PH_IDLE;
				end
			end
			mmtt_pkg::MODE_TICK: begin
				// advance the clock only while a transaction is pending
				if (phase_q != mmtt_pkg::PH_IDLE) begin
					elapsed_d = elapsed_inc;
					if (elapsed_inc > timeout_q) begin
						res_d.event_res = mmtt_pkg::EV_FAIL;
						res_d.status    = mmtt_pkg::ST_TIMEOUT;
						phase_d         = mmtt_pkg::PH_IDLE;
					end
				end
			end
			default: begin
				res_d.event_res = mmtt_pkg::EV_NONE;
			end
		endcase

		res_d.busy_res      = (phase_d != mmtt_pkg::PH_IDLE);
		res_d.write_pending = (phase_d == mmtt_pkg::PH_WRITE);
	end

	// control and transaction state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			timeout_q   <= mmtt_pkg::TIMEOUT_RESET;
			phase_q     <= mmtt_pkg::PH_IDLE;
			pend_fn_q   <= 8'd0;
			pend_addr_q <= 16'd0;
			pend_elen_q <= 8'd0;
			pend_wval_q <= 16'd0;
			elapsed_q   <= 32'd0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2    <= 1'b1;
				phase_q     <= phase_d;
				pend_fn_q   <= pend_fn_d;
				pend_addr_q <= pend_addr_d;
				pend_elen_q <= pend_elen_d;
				pend_wval_q <= pend_wval_d;
				elapsed_q   <= elapsed_d;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
			if (cfg_wr_en) begin
				timeout_q <= cfg_wr_data;
			end
		end
	end

	// payload registers: hold the beat and the result
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	// busy flag in a fresh result tracks the phase that was committed with it
	a_busy_matches_phase: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (res_s2.busy_res == (phase_q != mmtt_pkg::PH_IDLE)))
		else $error("result busy flag disagrees with tracker phase");

	// a sent request always leaves a transaction pending
	a_sent_is_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.event_res == mmtt_pkg::EV_SENT) |-> res_s2.busy_res)
		else $error("request sent without a pending transaction");

	// request fields stay zero unless a request is sent
	a_send_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.event_res != mmtt_pkg::EV_SENT) |->
		(res_s2.send_function == 8'd0 && res_s2.send_address == 16'd0 &&
		 res_s2.send_count == 7'd0 && res_s2.send_bytes == 8'd0))
		else $error("request fields set on a non-send result");

	// a refused command leaves the pending transaction untouched
	a_refuse_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_d.event_res == mmtt_pkg::EV_REFUSED) |=>
		(phase_q == $past(phase_q) && pend_addr_q == $past(pend_addr_q) &&
		 elapsed_q == $past(elapsed_q)))
		else $error("refused command changed the pending transaction");

endmodule

`default_nettype wire

### tb/modbus_master_transaction_tracker_tb.sv
// ----------------------------------------------------------------------------
// modbus_master_transaction_tracker_tb: self-checking bench for the tracker
// Drives commands, response summaries, exceptions and ticks through the
// valid/ready input, mirrors the tracker in a behavioural model, and compares
// every result beat field by field under random stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modbus_master_transaction_tracker_tb;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	mmtt_pkg::in_item_t  in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	mmtt_pkg::out_item_t out_data;
	logic                cfg_wr_en = 1'b0;
	logic [31:0]         cfg_wr_data = '0;

	modbus_master_transaction_tracker DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// Mirror of the tracker: the pending transaction and the timeout register.
	mmtt_pkg::phase_t trk_phase = mmtt_pkg::PH_IDLE;
	logic [7:0]       trk_function = '0;
	logic [15:0]      trk_address = '0;
	logic [7:0]       trk_read_len = '0;
	logic [15:0]      trk_write_value = '0;
	logic [31:0]      trk_elapsed = '0;
	logic [31:0]      timeout_limit = mmtt_pkg::TIMEOUT_RESET;

	mmtt_pkg::out_item_t outcome_q[$];     // predicted result beats, oldest first
	int unsigned mismatches = 0;
	int unsigned beats_sent = 0;
	bit          calm = 1'b0;      // set to drop all random idling on both sides
	int          hold_cycles = 0;  // receiver hold-off, counted down by the receiver

	initial begin
		forever #1 clk = ~clk;
	end

	// Watchdog: far beyond the slowest legal run (some five hundred beats).
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Behavioural model of the tracker
	// ------------------------------------------------------------------------

	// Start a transaction: latch what the response will be checked against.
	function automatic void open_transaction(input mmtt_pkg::phase_t ph,
			input mmtt_pkg::in_item_t b, input logic [15:0] wval);
		trk_phase       = ph;
		trk_function    = b.function_select;
		trk_address     = b.target_address;
		trk_read_len    = b.expected_length;
		trk_write_value = wval;
		trk_elapsed     = '0;
	endfunction

	// Advance the model by one beat and return the result beat it must give.
	function automatic mmtt_pkg::out_item_t track_beat(input mmtt_pkg::in_item_t b);
		mmtt_pkg::out_item_t r;
		logic [7:0]          padded;
		r = '0;
		case (b.mode)
			mmtt_pkg::MODE_ISSUE: begin
				if (trk_phase != mmtt_pkg::PH_IDLE) begin
					r.event_res = mmtt_pkg::EV_REFUSED;
					r.status    = mmtt_pkg::ST_BUSY;
				end else if (b.function_select == mmtt_pkg::FN_READ_INPUT) begin
					r.event_res  = mmtt_pkg::EV_SENT;
					r.send_count = b.expected_length[7:1];
					open_transaction(mmtt_pkg::PH_READ, b, 16'h0000);
				end else if (b.function_select == mmtt_pkg::FN_WRITE_ONE &&
						(b.payload_length == 8'd1 || b.payload_length == 8'd2)) begin
					r.event_res  = mmtt_pkg::EV_SENT;
					r.send_count = 7'd1;
					r.send_bytes = 8'd2;
					// a one-byte value sits in the low half, high byte padded with zero
					open_transaction(mmtt_pkg::PH_WRITE, b, (b.payload_length == 8'd1) ?
						{8'h00, b.payload_value[7:0]} : b.payload_value);
				end else if (b.function_select == mmtt_pkg::FN_WRITE_MANY &&
						b.payload_length <= mmtt_pkg::MAX_WRITE_BYTES) begin
					// round the byte count up to a whole register
					padded       = b.payload_length + {7'd0, b.payload_length[0]};
					r.event_res  = mmtt_pkg::EV_SENT;
					r.send_count = padded[7:1];
					r.send_bytes = padded;
					open_transaction(mmtt_pkg::PH_WRITE, b, 16'h0000);
				end else begin
					r.event_res = mmtt_pkg::EV_REFUSED;
					r.status    = mmtt_pkg::ST_PROTOCOL;
				end
				if (r.event_res == mmtt_pkg::EV_SENT) begin
					r.send_function = b.function_select;
					r.send_address  = b.target_address;
				end
			end
			mmtt_pkg::MODE_RESPONSE: begin
				r.event_res = mmtt_pkg::EV_FAIL;
				if (trk_phase == mmtt_pkg::PH_IDLE) begin
					r.status = mmtt_pkg::ST_NO_TRANS;
				end else begin
					if (b.response_length == 8'd0) begin
						r.status = mmtt_pkg::ST_PROTOCOL;
					end else if (trk_phase == mmtt_pkg::PH_READ) begin
						if (b.response_length != trk_read_len)
							r.status = mmtt_pkg::ST_PROTOCOL;
						else
							r.event_res = mmtt_pkg::EV_OK;
					end else if (b.response_length < mmtt_pkg::MIN_WRITE_RESP ||
							b.response_address != trk_address) begin
						r.status = mmtt_pkg::ST_PROTOCOL;
					end else if (trk_function == mmtt_pkg::FN_WRITE_ONE &&
							b.echo_value == mmtt_pkg::REJECT_MARK) begin
						r.status = mmtt_pkg::ST_MODBUS;
					end else if (trk_function == mmtt_pkg::FN_WRITE_ONE &&
							b.echo_value != trk_write_value) begin
						r.status = mmtt_pkg::ST_INVALID;
					end else begin
						// the echoed count of a multiple write is not checked
						r.event_res = mmtt_pkg::EV_OK;
					end
					trk_phase = mmtt_pkg::PH_IDLE;
				end
			end
			mmtt_pkg::MODE_EXCEPTION: begin
				r.event_res = mmtt_pkg::EV_FAIL;
				if (trk_phase == mmtt_pkg::PH_IDLE) begin
					r.status = mmtt_pkg::ST_NO_TRANS;
				end else begin
					r.status  = mmtt_pkg::ST_MODBUS;
					trk_phase = mmtt_pkg::PH_IDLE;
				end
			end
			default: begin
				// a tick only counts while a transaction is pending; the count saturates
				if (trk_phase != mmtt_pkg::PH_IDLE) begin
					if (trk_elapsed != '1)
						trk_elapsed++;
					if (trk_elapsed > timeout_limit) begin
						r.event_res = mmtt_pkg::EV_FAIL;
						r.status    = mmtt_pkg::ST_TIMEOUT;
						trk_phase   = mmtt_pkg::PH_IDLE;
					end
				end
			end
		endcase
		r.busy_res      = (trk_phase != mmtt_pkg::PH_IDLE);
		r.write_pending = (trk_phase == mmtt_pkg::PH_WRITE);
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Result side: stall at random, hold off on request, check each beat
	// ------------------------------------------------------------------------

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		// sample the beat taken at this edge before driving ready for the next
		if (arst_n && out_valid && out_ready) begin
			if (outcome_q.size() == 0) begin
				$display("%0t: result beat expected none, got %h", $time, out_data);
				mismatches++;
			end else begin
				mmtt_pkg::out_item_t want;
				want = outcome_q.pop_front();
				check_field("event_res", 32'(want.event_res), 32'(out_data.event_res));
				check_field("status", 32'(want.status), 32'(out_data.status));
				check_field("send_function", 32'(want.send_function),
					32'(out_data.send_function));
				check_field("send_address", 32'(want.send_address),
					32'(out_data.send_address));
				check_field("send_count", 32'(want.send_count), 32'(out_data.send_count));
				check_field("send_bytes", 32'(want.send_bytes), 32'(out_data.send_bytes));
				check_field("busy_res", 32'(want.busy_res), 32'(out_data.busy_res));
				check_field("write_pending", 32'(want.write_pending),
					32'(out_data.write_pending));
			end
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= 9);
		end
	end

	// ------------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------------

	// Offer one beat, idling now and then first; predict it once it is taken.
	task automatic send_item(input mmtt_pkg::in_item_t it);
		if (!calm && $urandom_range(99) < 9) begin
			if (in_valid)
				in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		outcome_q = {outcome_q, track_beat(it)};
		beats_sent++;
	endtask

	// Drop valid and hold until every predicted beat has come back.
	task automatic wait_drained();
		if (in_valid)
			in_valid <= 1'b0;
		while (outcome_q.size() != 0) @(posedge clk);
	endtask

	// Write the timeout register; call only with nothing in flight.
	task automatic write_timeout(input logic [31:0] ticks);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= ticks;
		@(posedge clk);
		cfg_wr_en     <= 1'b0;
		timeout_limit  = ticks;
	endtask

	// A beat of the given kind; the fields it does not use carry random noise.
	function automatic mmtt_pkg::in_item_t beat_of(input logic [1:0] mode);
		mmtt_pkg::in_item_t b;
		b.mode             = mode;
		b.function_select  = 8'($urandom);
		b.target_address   = 16'($urandom);
		b.payload_length   = 8'($urandom);
		b.payload_value    = 16'($urandom);
		b.expected_length  = 8'($urandom);
		b.response_length  = 8'($urandom);
		b.response_address = 16'($urandom);
		b.echo_value       = 16'($urandom);
		return b;
	endfunction

	function automatic mmtt_pkg::in_item_t command(input logic [7:0] fn,
			input logic [15:0] addr, input logic [7:0] plen, input logic [15:0] pval,
			input logic [7:0] elen);
		mmtt_pkg::in_item_t b;
		b                 = beat_of(mmtt_pkg::MODE_ISSUE);
		b.function_select = fn;
		b.target_address  = addr;
		b.payload_length  = plen;
		b.payload_value   = pval;
		b.expected_length = elen;
		return b;
	endfunction

	function automatic mmtt_pkg::in_item_t reply(input logic [7:0] rlen,
			input logic [15:0] raddr, input logic [15:0] rval);
		mmtt_pkg::in_item_t b;
		b                  = beat_of(mmtt_pkg::MODE_RESPONSE);
		b.response_length  = rlen;
		b.response_address = raddr;
		b.echo_value       = rval;
		return b;
	endfunction

	// One transaction with random content: a command, some ticks, then an
	// answer that is mostly right and sometimes broken, late or missing.
	task automatic random_exchange();
		mmtt_pkg::in_item_t cmd;
		mmtt_pkg::in_item_t rsp;
		int unsigned        pick;
		logic [15:0]        echo;
		cmd  = beat_of(mmtt_pkg::MODE_ISSUE);
		pick = $urandom_range(99);
		if (pick < 35)
			cmd.function_select = mmtt_pkg::FN_READ_INPUT;
		else if (pick < 65)
			cmd.function_select = mmtt_pkg::FN_WRITE_ONE;
		else if (pick < 92)
			cmd.function_select = mmtt_pkg::FN_WRITE_MANY;
		if (cmd.function_select == mmtt_pkg::FN_WRITE_ONE && $urandom_range(9) != 0)
			cmd.payload_length = 8'($urandom_range(1, 2));
		else if (cmd.function_select == mmtt_pkg::FN_WRITE_MANY && $urandom_range(9) != 0)
			cmd.payload_length = 8'($urandom_range(0, mmtt_pkg::MAX_WRITE_BYTES));
		send_item(cmd);
		// now and then a second command while the first is still open
		if ($urandom_range(9) == 0)
			send_item(beat_of(mmtt_pkg::MODE_ISSUE));
		repeat ($urandom_range(0, 8)) send_item(beat_of(mmtt_pkg::MODE_TICK));

		echo = (cmd.payload_length == 8'd1) ? {8'h00, cmd.payload_value[7:0]} :
			cmd.payload_value;
		rsp  = beat_of(mmtt_pkg::MODE_RESPONSE);
		if (cmd.function_select == mmtt_pkg::FN_READ_INPUT) begin
			rsp.response_length = cmd.expected_length;
		end else begin
			rsp.response_length  = 8'($urandom_range(mmtt_pkg::MIN_WRITE_RESP, 255));
			rsp.response_address = cmd.target_address;
			if (cmd.function_select == mmtt_pkg::FN_WRITE_ONE)
				rsp.echo_value = echo;
		end
		pick = $urandom_range(99);
		if (pick < 70)
			send_item(rsp);
		else if (pick < 78) begin
			rsp.response_length ^= 8'd1 << $urandom_range(7);
			send_item(rsp);
		end else if (pick < 84) begin
			rsp.response_address ^= 16'd1 << $urandom_range(15);
			send_item(rsp);
		end else if (pick < 88) begin
			rsp.echo_value ^= 16'd1 << $urandom_range(15);
			send_item(rsp);
		end else if (pick < 91) begin
			rsp.echo_value = mmtt_pkg::REJECT_MARK;
			send_item(rsp);
		end else if (pick < 95) begin
			send_item(beat_of(mmtt_pkg::MODE_EXCEPTION));
		end
		// otherwise leave it open: the next command is refused or it times out
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Reset timeout of 4000: a pending read outlives a run of ticks.
	task automatic test_default_timeout();
		send_item(command(mmtt_pkg::FN_READ_INPUT, 16'h0100, 8'd0, 16'h0000, 8'd4));
		repeat (40) send_item(beat_of(mmtt_pkg::MODE_TICK));
		send_item(beat_of(mmtt_pkg::MODE_EXCEPTION));
		wait_drained();
	endtask

	// Field extremes, every operation, every refusal and every failure path but the timeout.
	task automatic test_directed();
		send_item(beat_of(mmtt_pkg::MODE_TICK));            // tick while idle
		send_item(reply(8'd1, 16'h0000, 16'h0000));         // response with nothing open
		send_item(beat_of(mmtt_pkg::MODE_EXCEPTION));       // exception with nothing open
		send_item(command(mmtt_pkg::FN_READ_INPUT, 16'hFFFF, 8'h00, 16'h0000, 8'hFF));
		send_item(command(mmtt_pkg::FN_WRITE_ONE, 16'h0002, 8'd2, 16'h1234, 8'd0)); // busy
		send_item(reply(8'hFF, 16'h0000, 16'h0000));        // read, right length
		send_item(command(mmtt_pkg::FN_READ_INPUT, 16'h0000, 8'hFF, 16'hFFFF, 8'd0));
		send_item(reply(8'd0, 16'h0000, 16'h0000));         // empty response
		send_item(command(mmtt_pkg::FN_READ_INPUT, 16'h1234, 8'd0, 16'h0000, 8'd8));
		send_item(reply(8'd7, 16'h1234, 16'h0000));         // read, wrong length
		send_item(command(mmtt_pkg::FN_WRITE_ONE, 16'hA55A, 8'd1, 16'hABCD, 8'd0));
		send_item(reply(8'd4, 16'hA55A, 16'h00CD));         // one-byte value echoed
		send_item(command(mmtt_pkg::FN_WRITE_ONE, 16'h0001, 8'd2, 16'h1234, 8'd0));
		send_item(reply(8'd4, 16'h0001, mmtt_pkg::REJECT_MARK)); // reject marker
		send_item(command(mmtt_pkg::FN_WRITE_ONE, 16'h8000, 8'd2, 16'h8001, 8'd0));
		send_item(reply(8'hFF, 16'h8000, 16'h8000));        // echo differs
		send_item(command(mmtt_pkg::FN_WRITE_ONE, 16'h0000, 8'd0, 16'h0000, 8'd0));
		send_item(command(mmtt_pkg::FN_WRITE_ONE, 16'h0000, 8'd3, 16'h0000, 8'd0));
		send_item(command(mmtt_pkg::FN_WRITE_MANY, 16'h0000, 8'd0, 16'h0000, 8'd0));
		send_item(reply(8'd3, 16'h0000, 16'h0000));         // write answer too short
		send_item(command(mmtt_pkg::FN_WRITE_MANY, 16'hFFFF, 8'd245, 16'h0000, 8'd0));
		send_item(reply(8'd4, 16'hFFFE, 16'h007B));         // wrong echoed address
		send_item(command(mmtt_pkg::FN_WRITE_MANY, 16'h0001, mmtt_pkg::MAX_WRITE_BYTES,
			16'h0000, 8'd0));
		send_item(reply(8'd4, 16'h0001, 16'hFFFF));         // count echo not checked
		send_item(command(mmtt_pkg::FN_WRITE_MANY, 16'h0000, 8'd247, 16'h0000, 8'd0));
		send_item(command(mmtt_pkg::FN_WRITE_MANY, 16'h0000, 8'hFF, 16'h0000, 8'd0));
		send_item(command(8'h00, 16'h0000, 8'd2, 16'h0000, 8'd0));
		send_item(command(8'hFF, 16'hFFFF, 8'd2, 16'h0000, 8'd0));
		send_item(command(mmtt_pkg::FN_READ_INPUT, 16'h5555, 8'd0, 16'h0000, 8'd2));
		send_item(beat_of(mmtt_pkg::MODE_EXCEPTION));       // exception while pending
		wait_drained();
	endtask

	// Timeout register at its extremes: 0 fails on the first tick, all-ones never.
	task automatic test_timeout_extremes();
		logic [31:0] limits [4];
		limits = '{32'd0, 32'd1, 32'd2, 32'hFFFF_FFFF};
		foreach (limits[i]) begin
			wait_drained();
			write_timeout(limits[i]);
			send_item(command(mmtt_pkg::FN_WRITE_MANY, 16'h0042, 8'd5, 16'h0000, 8'd0));
			repeat ((limits[i] == '1) ? 60 : limits[i] + 2)
				send_item(beat_of(mmtt_pkg::MODE_TICK));
			send_item(beat_of(mmtt_pkg::MODE_EXCEPTION));
		end
		wait_drained();
	endtask

	// Hold the result side off while beats keep coming, so the input stalls.
	task automatic test_backpressure();
		wait_drained();
		hold_cycles = 40;
		repeat (4) random_exchange();
		wait_drained();
	endtask

	// Random transactions under three timeout settings, the middle one calm.
	task automatic test_random_traffic();
		int unsigned stop_at;
		for (int setting = 0; setting < 3; setting++) begin
			wait_drained();
			case (setting)
				0:       write_timeout($urandom_range(1, 6));
				1:       write_timeout($urandom_range(7, 40));
				default: write_timeout($urandom);
			endcase
			calm    = (setting == 1);
			stop_at = beats_sent + 120;
			while (beats_sent < stop_at) begin
				if ($urandom_range(9) == 0)
					send_item(beat_of(2'($urandom_range(3))));
				else
					random_exchange();
			end
		end
		calm = 1'b0;
		wait_drained();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_timeout();
		test_directed();
		test_timeout_extremes();
		test_backpressure();
		test_random_traffic();

		// let any stray beat show up before the verdict
		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
